[sv/ipc_pkg.sv]
`timescale 1ns / 1ps
// Shared package for the integer property classifier.
// Holds the width default, fixed constants and the sequencer state type; no dependencies.
package ipc_pkg;

	localparam int unsigned VALUE_WIDTH_DEF = 32;

	// Binary search bounds for the cube root; the upper bound covers 32-bit magnitudes.
	localparam int unsigned CUBE_W  = 12;
	localparam int unsigned CUBE_HI = 2048;

	// Constant divisors. Each has a reciprocal and shift that give the exact quotient
	// of any 32-bit unsigned word in one multiply.
	localparam int unsigned DEC_BASE  = 10;
	localparam int unsigned FIG_MOD   = 6;
	localparam logic [31:0] DEC_RECIP = 32'hCCCC_CCCD;
	localparam int unsigned DEC_SHIFT = 35;
	localparam logic [31:0] FIG_RECIP = 32'hAAAA_AAAB;
	localparam int unsigned FIG_SHIFT = 34;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQRT,
		ST_DIV,
		ST_PENT_CHK,
		ST_OCT_CHK,
		ST_CUBE_MUL,
		ST_CUBE_CMP,
		ST_PAL_STEP,
		ST_PAL_ACC,
		ST_TRIAL_STEP,
		ST_TRIAL_ACC,
		ST_DONE
	} state_t;

endpackage

[sv/integer_property_classifier_core.sv]
`timescale 1ns / 1ps
// Integer property classifier: sequencer around a shared restoring divider for the trial
// divisors, a reciprocal multiplier for the constant divisors, a bit-pair square root
// step and a cube-root binary search. Depends on ipc_pkg.
//
// For positive n the trial divisors run from 2 up to sqrt(n), so the run time grows with
// the square root of the value, on top of the root, cube and decimal digit work. The
// shared divider gives one quotient bit per cycle. One word at a time: busy stays high
// until the result strobe. Reset (arst_n low) returns the sequencer to idle at once; the
// result strobe done lasts one cycle and the receiver cannot stall it.
module integer_property_classifier_core #(
	parameter int unsigned VALUE_WIDTH = ipc_pkg::VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [VALUE_WIDTH-1:0] value,
	output logic                          done,
	output logic                          is_odd_flag,
	output logic                          is_prime_flag,
	output logic                          is_composite_flag,
	output logic                          is_square_flag,
	output logic                          is_cube_flag,
	output logic                          is_triangular_flag,
	output logic                          is_pentagonal_flag,
	output logic                          is_hexagonal_flag,
	output logic                          is_octagonal_flag,
	output logic                          is_palindrome_flag,
	output logic                          is_perfect_flag
);

	localparam int unsigned W    = VALUE_WIDTH;
	// The square root runs on 24|n|+1, which needs W+5 bits; rounded up to even.
	localparam int unsigned SW   = ((W + 7) / 2) * 2;
	// Trial divisor and its square; the divisor never exceeds sqrt(2^(W-1)) + 1.
	localparam int unsigned DW   = W / 2 + 2;
	localparam int unsigned QW   = W + 2;
	// Reversed decimal digits and divisor sums can exceed the input range.
	localparam int unsigned RW   = W + 4;
	localparam int unsigned CNTW = $clog2(W);
	localparam int unsigned CW   = ipc_pkg::CUBE_W;
	localparam int unsigned C2W  = 2 * CW;
	localparam int unsigned C3W  = 3 * CW;

	ipc_pkg::state_t state_q, state_d, ret_q, ret_d;

	logic          neg_q, neg_d, pos_q, pos_d;
	logic [W-1:0]  mag_q, mag_d;

	// Square root unit.
	logic [1:0]    sq_sel_q, sq_sel_d;
	logic [SW-1:0] sqx_q, sqx_d, sqr_q, sqr_d, sqb_q, sqb_d;
	logic [3:0]    sq_ok_q, sq_ok_d;
	logic [W-1:0]  s24_q, s24_d, s12_q, s12_d;
	logic          hex_ok_q, hex_ok_d, pent_ok_q, pent_ok_d, oct_ok_q, oct_ok_d;

	// Shared restoring divider.
	logic [W-1:0]    dq_q, dq_d, dr_q, dr_d, dv_q, dv_d;
	logic [CNTW-1:0] dcnt_q, dcnt_d;

	// Cube root search.
	logic [CW-1:0]   lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
	logic [2*CW-1:0] csq_q, csq_d;
	logic            cfin_q, cfin_d, cube_ok_q, cube_ok_d;

	// Palindrome and trial division.
	logic [W-1:0]  t_q, t_d;
	logic [RW-1:0] rev_q, rev_d, sum_q, sum_d;
	logic          pal_ok_q, pal_ok_d, has_div_q, has_div_d;
	logic [DW-1:0] d_q, d_d;
	logic [QW-1:0] dsq_q, dsq_d;

	// Input decode.
	logic [W-1:0]  mag_in;

	// Datapath step results.
	logic [SW-1:0] sq_t, sqx_n, sqr_n;
	logic          sq_ge;
	logic [W:0]    div_trial;
	logic [W-1:0]  dr_n;
	logic          qbit;
	logic [CW:0]   csum;
	logic [C3W-1:0] cprod;
	logic [W-1:0]  mag_x8;

	// Reciprocal quotient for the constant divisors 10 and 6.
	logic          cd_dec;
	logic [31:0]   cd_x, cd_quo;
	logic [63:0]   cd_prod;
	logic [W-1:0]  pal_dig;

	assign mag_in = value[W-1] ? W'(-value) : W'(value);

	assign sq_t  = sqr_q + sqb_q;
	assign sq_ge = sqx_q >= sq_t;
	assign sqx_n = sq_ge ? sqx_q - sq_t : sqx_q;
	assign sqr_n = sq_ge ? (sqr_q >> 1) + sqb_q : sqr_q >> 1;

	// One quotient bit per cycle; the dividend shifts out as the quotient shifts in.
	assign div_trial = {dr_q, dq_q[W-1]} - {1'b0, dv_q};
	assign qbit      = ~div_trial[W];
	assign dr_n      = qbit ? div_trial[W-1:0] : {dr_q[W-2:0], dq_q[W-1]};

	assign csum  = {1'b0, lo_q} + {1'b0, hi_q};
	assign cprod = C3W'(csq_q) * C3W'(mid_q);

	assign mag_x8 = mag_q;

	// The decimal step divides the remaining digits by ten; the figurate checks divide
	// the root plus its offset by six. Both quotients are exact for any 32-bit word.
	assign cd_dec  = (state_q == ipc_pkg::ST_PAL_STEP);
	assign cd_x    = (state_q == ipc_pkg::ST_PENT_CHK) ? 32'(s24_q) + 32'd1 :
	                 (state_q == ipc_pkg::ST_OCT_CHK)  ? 32'(s12_q) + 32'd2 : 32'(t_q);
	assign cd_prod = 64'(cd_x) * (cd_dec ? 64'(ipc_pkg::DEC_RECIP) : 64'(ipc_pkg::FIG_RECIP));
	assign cd_quo  = cd_dec ? 32'(cd_prod >> ipc_pkg::DEC_SHIFT)
	                        : 32'(cd_prod >> ipc_pkg::FIG_SHIFT);
	// Low decimal digit, from the quotient registered in the previous cycle.
	assign pal_dig = t_q - dq_q * W'(ipc_pkg::DEC_BASE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ipc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		ret_q     <= ret_d;
		neg_q     <= neg_d;
		pos_q     <= pos_d;
		mag_q     <= mag_d;
		sq_sel_q  <= sq_sel_d;
		sqx_q     <= sqx_d;
		sqr_q     <= sqr_d;
		sqb_q     <= sqb_d;
		sq_ok_q   <= sq_ok_d;
		s24_q     <= s24_d;
		s12_q     <= s12_d;
		hex_ok_q  <= hex_ok_d;
		pent_ok_q <= pent_ok_d;
		oct_ok_q  <= oct_ok_d;
		dq_q      <= dq_d;
		dr_q      <= dr_d;
		dv_q      <= dv_d;
		dcnt_q    <= dcnt_d;
		lo_q      <= lo_d;
		hi_q      <= hi_d;
		mid_q     <= mid_d;
		csq_q     <= csq_d;
		cfin_q    <= cfin_d;
		cube_ok_q <= cube_ok_d;
		t_q       <= t_d;
		rev_q     <= rev_d;
		sum_q     <= sum_d;
		pal_ok_q  <= pal_ok_d;
		has_div_q <= has_div_d;
		d_q       <= d_d;
		dsq_q     <= dsq_d;
	end

	always_comb begin
		state_d   = state_q;
		ret_d     = ret_q;
		neg_d     = neg_q;
		pos_d     = pos_q;
		mag_d     = mag_q;
		sq_sel_d  = sq_sel_q;
		sqx_d     = sqx_q;
		sqr_d     = sqr_q;
		sqb_d     = sqb_q;
		sq_ok_d   = sq_ok_q;
		s24_d     = s24_q;
		s12_d     = s12_q;
		hex_ok_d  = hex_ok_q;
		pent_ok_d = pent_ok_q;
		oct_ok_d  = oct_ok_q;
		dq_d      = dq_q;
		dr_d      = dr_q;
		dv_d      = dv_q;
		dcnt_d    = dcnt_q;
		lo_d      = lo_q;
		hi_d      = hi_q;
		mid_d     = mid_q;
		csq_d     = csq_q;
		cfin_d    = cfin_q;
		cube_ok_d = cube_ok_q;
		t_d       = t_q;
		rev_d     = rev_q;
		sum_d     = sum_q;
		pal_ok_d  = pal_ok_q;
		has_div_d = has_div_q;
		d_d       = d_q;
		dsq_d     = dsq_q;

		unique case (state_q)
			ipc_pkg::ST_IDLE: begin
				if (start) begin
					neg_d    = value[W-1];
					pos_d    = ~value[W-1] && (value != '0);
					mag_d    = mag_in;
					sq_sel_d = 2'd0;
					sqx_d    = SW'(mag_in);
					sqr_d    = '0;
					sqb_d    = SW'(1) << (SW - 2);
					state_d  = ipc_pkg::ST_SQRT;
				end
			end
			// Four roots in turn: |n|, 8|n|+1, 24|n|+1 and 12|n|+4.
			ipc_pkg::ST_SQRT: begin
				sqx_d = sqx_n;
				sqr_d = sqr_n;
				sqb_d = sqb_q >> 2;
				if (sqb_q == SW'(1)) begin
					sq_ok_d[sq_sel_q] = (sqx_n == '0);
					sqr_d    = '0;
					sqb_d    = SW'(1) << (SW - 2);
					sq_sel_d = sq_sel_q + 2'd1;
					unique case (sq_sel_q)
						2'd0: sqx_d = (SW'(mag_x8) << 3) + SW'(1);
						2'd1: begin
							hex_ok_d = (sqr_n[1:0] == 2'b11);
							sqx_d = (SW'(mag_q) << 4) + (SW'(mag_q) << 3) + SW'(1);
						end
						2'd2: begin
							s24_d = W'(sqr_n);
							sqx_d = (SW'(mag_q) << 3) + (SW'(mag_q) << 2) + SW'(4);
						end
						2'd3: begin
							s12_d   = W'(sqr_n);
							state_d = ipc_pkg::ST_PENT_CHK;
						end
						default: state_d = ipc_pkg::ST_IDLE;
					endcase
				end
			end
			ipc_pkg::ST_DIV: begin
				dr_d   = dr_n;
				dq_d   = {dq_q[W-2:0], qbit};
				dcnt_d = dcnt_q - CNTW'(1);
				if (dcnt_q == '0) begin
					state_d = ret_q;
				end
			end
			ipc_pkg::ST_PENT_CHK: begin
				pent_ok_d = (cd_x == cd_quo * 32'(ipc_pkg::FIG_MOD));
				state_d   = ipc_pkg::ST_OCT_CHK;
			end
			ipc_pkg::ST_OCT_CHK: begin
				oct_ok_d = (cd_x == cd_quo * 32'(ipc_pkg::FIG_MOD));
				lo_d     = '0;
				hi_d     = CW'(ipc_pkg::CUBE_HI);
				state_d  = ipc_pkg::ST_CUBE_MUL;
			end
			// Once the search interval closes, one more pass cubes the bound itself.
			ipc_pkg::ST_CUBE_MUL: begin
				if (lo_q < hi_q) begin
					mid_d  = csum[CW:1];
					csq_d  = C2W'(csum[CW:1]) * C2W'(csum[CW:1]);
					cfin_d = 1'b0;
				end else begin
					mid_d  = lo_q;
					csq_d  = C2W'(lo_q) * C2W'(lo_q);
					cfin_d = 1'b1;
				end
				state_d = ipc_pkg::ST_CUBE_CMP;
			end
			ipc_pkg::ST_CUBE_CMP: begin
				if (cfin_q) begin
					cube_ok_d = (cprod == C3W'(mag_q));
					t_d       = mag_q;
					rev_d     = '0;
					state_d   = ipc_pkg::ST_PAL_STEP;
				end else begin
					if (cprod < C3W'(mag_q)) begin
						lo_d = mid_q + CW'(1);
					end else begin
						hi_d = mid_q;
					end
					state_d = ipc_pkg::ST_CUBE_MUL;
				end
			end
			// Peel decimal digits off, low digit first: quotient here, digit next cycle.
			ipc_pkg::ST_PAL_STEP: begin
				if (t_q == '0) begin
					pal_ok_d  = (rev_q == RW'(mag_q));
					d_d       = DW'(2);
					dsq_d     = QW'(4);
					sum_d     = RW'(1);
					has_div_d = 1'b0;
					state_d   = ipc_pkg::ST_TRIAL_STEP;
				end else begin
					dq_d    = W'(cd_quo);
					state_d = ipc_pkg::ST_PAL_ACC;
				end
			end
			ipc_pkg::ST_PAL_ACC: begin
				rev_d   = (rev_q << 3) + (rev_q << 1) + RW'(pal_dig);
				t_d     = dq_q;
				state_d = ipc_pkg::ST_PAL_STEP;
			end
			// One loop over d = 2 .. sqrt(n) serves both primality and the divisor sum.
			ipc_pkg::ST_TRIAL_STEP: begin
				if (!pos_q || mag_q < W'(2) || dsq_q > QW'(mag_q)) begin
					state_d = ipc_pkg::ST_DONE;
				end else begin
					dq_d    = mag_q;
					dr_d    = '0;
					dv_d    = W'(d_q);
					dcnt_d  = CNTW'(W - 1);
					ret_d   = ipc_pkg::ST_TRIAL_ACC;
					state_d = ipc_pkg::ST_DIV;
				end
			end
			ipc_pkg::ST_TRIAL_ACC: begin
				if (dr_q == '0) begin
					has_div_d = 1'b1;
					if (dq_q != W'(d_q)) begin
						sum_d = sum_q + RW'(d_q) + RW'(dq_q);
					end else begin
						sum_d = sum_q + RW'(d_q);
					end
				end
				dsq_d   = dsq_q + (QW'(d_q) << 1) + QW'(1);
				d_d     = d_q + DW'(1);
				state_d = ipc_pkg::ST_TRIAL_STEP;
			end
			ipc_pkg::ST_DONE: begin
				state_d = ipc_pkg::ST_IDLE;
			end
			default: state_d = ipc_pkg::ST_IDLE;
		endcase
	end

	assign busy = (state_q != ipc_pkg::ST_IDLE);
	assign done = (state_q == ipc_pkg::ST_DONE);

	// Flags come straight from the working registers, which hold still during the strobe.
	assign is_odd_flag        = mag_q[0];
	assign is_prime_flag      = pos_q && (mag_q > W'(1)) && !has_div_q;
	assign is_composite_flag  = pos_q && (mag_q > W'(1)) && has_div_q;
	assign is_square_flag     = pos_q && sq_ok_q[0];
	assign is_cube_flag       = (mag_q != '0) && cube_ok_q;
	assign is_triangular_flag = pos_q && sq_ok_q[1];
	assign is_pentagonal_flag = pos_q && sq_ok_q[2] && pent_ok_q;
	assign is_hexagonal_flag  = pos_q && sq_ok_q[1] && hex_ok_q;
	assign is_octagonal_flag  = pos_q && sq_ok_q[3] && oct_ok_q;
	assign is_palindrome_flag = !neg_q && pal_ok_q;
	assign is_perfect_flag    = pos_q && (mag_q >= W'(6)) && (sum_q == RW'(mag_q));

endmodule

[bench/integer_property_classifier_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for integer_property_classifier_core: a queue-fed driver, a monitor on
// the done strobe and a flag predictor using exact integer arithmetic. Depends on ipc_pkg.
module integer_property_classifier_core_tb;

	localparam int unsigned W = ipc_pkg::VALUE_WIDTH_DEF;

	typedef struct packed {
		logic odd;
		logic prime;
		logic composite;
		logic square;
		logic cube;
		logic triangular;
		logic pentagonal;
		logic hexagonal;
		logic octagonal;
		logic palindrome;
		logic perfect;
	} flags_t;

	logic                clk;
	logic                arst_n;
	logic                start = 1'b0;
	logic                busy;
	logic signed [W-1:0] value = '0;
	logic                done;
	flags_t              got;

	logic signed [W-1:0] pending_words[$];
	flags_t              expected_flags[$];
	logic                took = 1'b0;
	int unsigned         gap_left = 0;
	int unsigned         mismatches = 0;
	int unsigned         n_items = 0;
	int unsigned         n_results = 0;

	integer_property_classifier_core #(.VALUE_WIDTH(W)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.value(value),
		.done(done),
		.is_odd_flag(got.odd),
		.is_prime_flag(got.prime),
		.is_composite_flag(got.composite),
		.is_square_flag(got.square),
		.is_cube_flag(got.cube),
		.is_triangular_flag(got.triangular),
		.is_pentagonal_flag(got.pentagonal),
		.is_hexagonal_flag(got.hexagonal),
		.is_octagonal_flag(got.octagonal),
		.is_palindrome_flag(got.palindrome),
		.is_perfect_flag(got.perfect)
	);

	// Exact integer square root, one result bit per pass.
	function automatic longint unsigned int_sqrt(input longint unsigned x);
		longint unsigned res;
		longint unsigned bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > x)
			bitv >>= 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// Works out the eleven flags for one word. The magnitude is held in 64 bits so that
	// 8n+1, 12n+4 and 24n+1 never wrap, even for the most negative value.
	function automatic flags_t classify(input logic signed [W-1:0] v);
		flags_t          f;
		longint          n;
		longint unsigned mag;
		longint unsigned r;
		longint unsigned lo;
		longint unsigned hi;
		longint unsigned mid;
		longint unsigned d;
		longint unsigned sum;
		longint unsigned t;
		longint unsigned rev;
		logic            pos;
		n = v;
		mag = (n < 0) ? longint'(-n) : longint'(n);
		pos = n >= 1;
		f = '0;
		f.odd = mag[0];

		// Primality by odd trial divisors.
		if (n == 2) begin
			f.prime = 1'b1;
		end else if (n > 2 && mag[0]) begin
			f.prime = 1'b1;
			for (d = 3; d * d <= mag; d += 2)
				if (mag % d == 0) begin
					f.prime = 1'b0;
					break;
				end
		end
		f.composite = !f.prime && n > 1;

		r = int_sqrt(mag);
		f.square = pos && r * r == mag;

		// Cube root by binary search over the magnitude.
		lo = 0;
		hi = ipc_pkg::CUBE_HI;
		while (lo < hi) begin
			mid = (lo + hi) / 2;
			if (mid * mid * mid < mag)
				lo = mid + 1;
			else
				hi = mid;
		end
		f.cube = n != 0 && lo * lo * lo == mag;

		r = int_sqrt(8 * mag + 1);
		f.triangular = pos && r * r == 8 * mag + 1;
		f.hexagonal = f.triangular && (r + 1) % 4 == 0;
		r = int_sqrt(24 * mag + 1);
		f.pentagonal = pos && r * r == 24 * mag + 1 && (r + 1) % 6 == 0;
		r = int_sqrt(12 * mag + 4);
		f.octagonal = pos && r * r == 12 * mag + 4 && (r + 2) % 6 == 0;

		if (n >= 0) begin
			rev = 0;
			for (t = mag; t != 0; t /= 10)
				rev = rev * 10 + t % 10;
			f.palindrome = rev == mag;
		end

		// Perfect number by summing divisor pairs.
		if (n >= 6) begin
			sum = 1;
			for (d = 2; d * d <= mag; d++)
				if (mag % d == 0) begin
					sum += d;
					if (mag / d != d)
						sum += mag / d;
				end
			f.perfect = sum == mag;
		end
		return f;
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Driver: a new word goes out at a falling edge once the previous one was taken and
	// its random gap has run out. The next value of start is settled first so that it
	// sees only one assignment per edge.
	always @(negedge clk) begin
		logic next_start;
		next_start = start;
		if (took)
			next_start = 1'b0;
		if (arst_n && !next_start) begin
			if (gap_left > 0) begin
				gap_left--;
			end else if (pending_words.size() > 0) begin
				value <= pending_words.pop_front();
				next_start = 1'b1;
				gap_left = $urandom_range(0, 9);
			end
		end
		start <= next_start;
	end

	// Monitor: records accepted words and checks each done strobe against the oldest
	// expectation.
	always @(posedge clk) begin
		flags_t want;
		took <= arst_n && start && !busy;
		if (arst_n && start && !busy)
			expected_flags.push_back(classify(value));
		if (arst_n && done) begin
			n_results++;
			if (expected_flags.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word: flags %b", got);
			end else begin
				want = expected_flags.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("flag mismatch: expected %b, got %b", want, got);
				end
			end
		end
	end

	initial begin
		int k;
		int unsigned pick;

		// Directed words: extremes, both signs of zero-adjacent values, each figurate family,
		// cubes of either sign, palindromes and the small perfect numbers.
		pending_words = '{0, 1, 2, 3, 4, 9, 15, 21, 22, 45, 6, 28, 496, 8128, 27, -27, -8,
			-1, 121, -121, 12321, 40, 33550336, 32'sh8000_0000, 32'sh7FFF_FFFF};

		// Random words: mostly small magnitudes, since the block's time grows with the
		// square root of the value; a few medium positives, some full-width negatives for
		// the upper bits and one large positive.
		for (k = 0; k < 75; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 70)
				pending_words.push_back($signed($urandom_range(0, 8191)) - 4096);
			else if (pick < 85)
				pending_words.push_back($urandom_range(0, 1 << 20));
			else
				pending_words.push_back($urandom | 32'h8000_0000);
		end
		pending_words.push_back($urandom_range(32'h4000_0000, 32'h7FFF_FFFF));
		n_items = pending_words.size();

		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (n_results >= n_items);
		repeat (600) @(posedge clk);
		if (mismatches == 0 && expected_flags.size() == 0)
			$display("integer_property_classifier_core_tb passed");
		else
			$display("integer_property_classifier_core_tb failed");
		$finish;
	end

	// Two words near the top of the positive range dominate the run, since the block's time
	// grows with the square root of the value; this bound leaves a wide margin.
	initial begin
		#800ms;
		$display("integer_property_classifier_core_tb failed");
		$finish;
	end

endmodule
